@@ src/pcnms_pkg.sv @@
package pcnms_pkg;

  typedef struct packed {
    logic        operation;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score;
    logic        end_of_detection;
    logic        end_of_set;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [3:0]  class_index;
    logic [15:0] out_score;
    logic        last_class;
    logic        last_result;
    logic        overflow;
  } out_word_t;

  typedef struct packed {
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] top;
    logic [15:0] left;
  } box_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic CFG_IOU_THRESHOLD = 1'b0;
  localparam logic CFG_NUM_CLASSES   = 1'b1;

  localparam logic [15:0] IOU_THR_RESET     = 16'd29491;
  localparam logic [4:0]  NUM_CLASSES_RESET = 5'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_PICK_RD,
    ST_PICK_CHK,
    ST_BOX_LATCH,
    ST_SUP_RD,
    ST_SUP_CHK,
    ST_SUP_WAIT,
    ST_F_START,
    ST_SV_RD,
    ST_SV_CHK,
    ST_F_FIRST,
    ST_F_DATA,
    ST_EMIT
  } nms_state_t;

  typedef enum logic [2:0] {
    IU_IDLE,
    IU_EXT,
    IU_INTER,
    IU_AREA_A,
    IU_AREA_B,
    IU_UNION,
    IU_SCALE,
    IU_CMP
  } iou_step_t;

  typedef enum logic {
    SV_FIRST,
    SV_LAST
  } sv_ret_t;

endpackage

@@ src/pcnms_iou.sv @@
module pcnms_iou (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       thr,
  input  pcnms_pkg::box_t   box_a,
  input  pcnms_pkg::box_t   box_b,
  output logic              done,
  output logic              hit
);
  import pcnms_pkg::*;

  iou_step_t   step_r, step_nxt;
  box_t        a_r, b_r;
  logic [16:0] iw_r, ih_r;
  logic [33:0] inter_r;
  logic [31:0] pa_r, pb_r;
  logic [32:0] uni_r;
  logic [48:0] rhs_r;

  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] prod;

  logic [15:0] lo_x, lo_y;
  logic [16:0] hi_x, hi_y, ea_x, eb_x, ea_y, eb_y;

  always_comb begin
    lo_x = (a_r.left > b_r.left) ? a_r.left : b_r.left;
    lo_y = (a_r.top > b_r.top) ? a_r.top : b_r.top;
    ea_x = 17'(a_r.left) + 17'(a_r.width);
    eb_x = 17'(b_r.left) + 17'(b_r.width);
    ea_y = 17'(a_r.top) + 17'(a_r.height);
    eb_y = 17'(b_r.top) + 17'(b_r.height);
    hi_x = (ea_x < eb_x) ? ea_x : eb_x;
    hi_y = (ea_y < eb_y) ? ea_y : eb_y;
  end

  always_comb begin
    case (step_r)
      IU_INTER: begin
        mul_a = 33'(iw_r);
        mul_b = ih_r;
      end
      IU_AREA_A: begin
        mul_a = 33'(a_r.width);
        mul_b = 17'(a_r.height);
      end
      IU_AREA_B: begin
        mul_a = 33'(b_r.width);
        mul_b = 17'(b_r.height);
      end
      default: begin
        mul_a = uni_r;
        mul_b = 17'(thr);
      end
    endcase
    prod = 50'(mul_a) * 50'(mul_b);
  end

  always_comb begin
    step_nxt = step_r;
    case (step_r)
      IU_IDLE:   if (start) step_nxt = IU_EXT;
      IU_EXT:    step_nxt = IU_INTER;
      IU_INTER:  step_nxt = IU_AREA_A;
      IU_AREA_A: step_nxt = IU_AREA_B;
      IU_AREA_B: step_nxt = IU_UNION;
      IU_UNION:  step_nxt = IU_SCALE;
      IU_SCALE:  step_nxt = IU_CMP;
      IU_CMP:    step_nxt = IU_IDLE;
      default:   step_nxt = IU_IDLE;
    endcase
  end

  assign done = (step_r == IU_CMP);
  assign hit  = (uni_r != '0) && ({inter_r, 16'b0} > {1'b0, rhs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= IU_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      IU_IDLE: begin
        a_r <= box_a;
        b_r <= box_b;
      end
      IU_EXT: begin
        iw_r <= (hi_x > 17'(lo_x)) ? hi_x - 17'(lo_x) : '0;
        ih_r <= (hi_y > 17'(lo_y)) ? hi_y - 17'(lo_y) : '0;
      end
      IU_INTER:  inter_r <= prod[33:0];
      IU_AREA_A: pa_r <= prod[31:0];
      IU_AREA_B: pb_r <= prod[31:0];
      IU_UNION:  uni_r <= 33'(pa_r) + 33'(pb_r) - inter_r[32:0];
      IU_SCALE:  rhs_r <= prod[48:0];
      default: begin
      end
    endcase
  end

endmodule

@@ src/per_class_greedy_box_nms.sv @@
// channel | dir | handshake          | word
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// in      | in  | in_valid/in_stall  | in_data (load score or fetch)
// out     | out | out_valid/out_stall| out_data (one word per fetch)
// A load is taken in ST_IDLE; closing a short detection zero-fills each missing class in ST_FILL.
// The run after end_of_set scans, per class and pick, all stored detections to find the
// best score and again to suppress, testing IoU for each later nonzero score; one IoU unit.
// A fetch scans scores for the next survivor, alternating ST_SV_RD and ST_SV_CHK per score.
// in_stall is high whenever the sequencer is busy; a held result does not block loads.
// Reset is synchronous; store contents are kept, only control state and config registers clear.
module per_class_greedy_box_nms #(
  parameter int MAX_DETECTIONS = 256,
  parameter int MAX_CLASSES    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcnms_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcnms_pkg::out_word_t out_data
);
  import pcnms_pkg::*;

  localparam int DW    = $clog2(MAX_DETECTIONS);
  localparam int CNTW  = $clog2(MAX_DETECTIONS + 1);
  localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CCW   = $clog2(MAX_CLASSES + 1);
  localparam int FCW   = CCW + 1;
  localparam int DEPTH = MAX_DETECTIONS * MAX_CLASSES;
  localparam int SAW   = $clog2(DEPTH);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_DETECTIONS);

  function automatic logic [SAW-1:0] s_addr(input logic [DW-1:0] det,
                                            input logic [CW-1:0] cls);
    return SAW'(det) * SAW'(MAX_CLASSES) + SAW'(cls);
  endfunction

  nms_state_t      state_r, state_nxt;
  logic [15:0]     thr_r;
  logic [4:0]      ncls_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [CCW-1:0]  set_cls_r, set_cls_nxt;
  logic            ovf_r, ovf_nxt;
  logic            run_done_r, run_done_nxt;
  logic [CNTW-1:0] fp_det_r, fp_det_nxt;
  logic [CW-1:0]   fp_cls_r, fp_cls_nxt;
  logic [FCW-1:0]  fill_c_r, fill_c_nxt;
  logic [DW-1:0]   fill_det_r, fill_det_nxt;
  logic            eos_pend_r, eos_pend_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CNTW-1:0] d_r, d_nxt;
  logic [CNTW-1:0] best_r, best_nxt;
  logic [15:0]     best_s_r, best_s_nxt;
  logic            have_last_r, have_last_nxt;
  logic [15:0]     last_s_r, last_s_nxt;
  logic [CNTW-1:0] last_i_r, last_i_nxt;
  box_t            best_box_r, best_box_nxt;
  logic [CNTW-1:0] sv_d_r, sv_d_nxt;
  logic [CW-1:0]   sv_c_r, sv_c_nxt;
  sv_ret_t         sv_ret_r, sv_ret_nxt;
  logic [CNTW-1:0] cur_det_r, cur_det_nxt;
  logic [CW-1:0]   cur_cls_r, cur_cls_nxt;
  out_word_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic [15:0] score_mem [DEPTH];
  box_t        box_mem [MAX_DETECTIONS];
  logic [15:0] score_q;
  box_t        box_q;
  logic            s_we, s_re, b_we, b_re;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [15:0]     s_wdata;
  logic [DW-1:0]   b_waddr, b_raddr;
  box_t            b_wdata;

  logic [CCW-1:0] eff_cls;
  logic iou_start, iou_done, iou_hit;

  assign eff_cls = (ncls_r == '0) ? CCW'(1) :
                   (int'(ncls_r) > MAX_CLASSES) ? CCW'(MAX_CLASSES) : CCW'(ncls_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  pcnms_iou u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .start (iou_start),
    .thr   (thr_r),
    .box_a (best_box_r),
    .box_b (box_q),
    .done  (iou_done),
    .hit   (iou_hit)
  );

  always_comb begin
    logic [CNTW-1:0] lcnt;
    logic [CW-1:0]   lcur;
    logic [CCW-1:0]  lset;
    logic [FCW-1:0]  fstart;
    logic [DW-1:0]   fdet;
    logic            closing;
    logic            later;
    logic            start_run;
    logic            sv_go;
    logic [CNTW-1:0] found;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    set_cls_nxt   = set_cls_r;
    ovf_nxt       = ovf_r;
    run_done_nxt  = run_done_r;
    fp_det_nxt    = fp_det_r;
    fp_cls_nxt    = fp_cls_r;
    fill_c_nxt    = fill_c_r;
    fill_det_nxt  = fill_det_r;
    eos_pend_nxt  = eos_pend_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    best_s_nxt    = best_s_r;
    have_last_nxt = have_last_r;
    last_s_nxt    = last_s_r;
    last_i_nxt    = last_i_r;
    best_box_nxt  = best_box_r;
    sv_d_nxt      = sv_d_r;
    sv_c_nxt      = sv_c_r;
    sv_ret_nxt    = sv_ret_r;
    cur_det_nxt   = cur_det_r;
    cur_cls_nxt   = cur_cls_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0;
    s_re = 1'b0; s_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0;
    b_re = 1'b0; b_raddr = '0;
    iou_start = 1'b0;
    lcnt = cnt_r; lcur = cur_r; lset = set_cls_r;
    fstart = '0; fdet = '0; closing = 1'b0;
    start_run = 1'b0; sv_go = 1'b0; found = cnt_r;
    later = !have_last_r || (score_q < last_s_r) ||
            ((score_q == last_s_r) && (d_r > last_i_r));

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.operation == OP_FETCH) begin
          state_nxt = ST_F_START;
        end else if (in_valid) begin
          if (run_done_r) begin
            lcnt = '0;
            lcur = '0;
            ovf_nxt = 1'b0;
            run_done_nxt = 1'b0;
            fp_det_nxt = '0;
            fp_cls_nxt = '0;
          end
          lset = (lcnt == '0 && lcur == '0) ? eff_cls : set_cls_r;
          set_cls_nxt = lset;
          if (lcnt >= CNT_MAX) begin
            ovf_nxt = 1'b1;
          end else begin
            if (lcur == '0) begin
              b_we = 1'b1;
              b_waddr = lcnt[DW-1:0];
              b_wdata = '{height: in_data.box_height, width: in_data.box_width,
                          top: in_data.box_top, left: in_data.box_left};
            end
            s_we = 1'b1;
            s_waddr = s_addr(lcnt[DW-1:0], lcur);
            s_wdata = in_data.score;
            if (in_data.end_of_detection || (FCW'(lcur) + FCW'(1) >= FCW'(lset))) begin
              closing = 1'b1;
              fstart = FCW'(lcur) + FCW'(1);
              fdet = lcnt[DW-1:0];
              lcnt = lcnt + CNTW'(1);
              lcur = '0;
            end else begin
              lcur = lcur + CW'(1);
            end
          end
          if (in_data.end_of_set && lcur != '0) begin
            closing = 1'b1;
            fstart = FCW'(lcur) + FCW'(1);
            fdet = lcnt[DW-1:0];
            lcnt = lcnt + CNTW'(1);
            lcur = '0;
          end
          cnt_nxt = lcnt;
          cur_nxt = lcur;
          fill_c_nxt = fstart;
          fill_det_nxt = fdet;
          eos_pend_nxt = in_data.end_of_set;
          if (closing && fstart < FCW'(lset)) begin
            state_nxt = ST_FILL;
          end else if (in_data.end_of_set) begin
            start_run = 1'b1;
          end
        end
      end

      ST_FILL: begin
        s_we = 1'b1;
        s_waddr = s_addr(fill_det_r, fill_c_r[CW-1:0]);
        s_wdata = '0;
        fill_c_nxt = fill_c_r + FCW'(1);
        if (fill_c_r + FCW'(1) >= FCW'(set_cls_r)) begin
          if (eos_pend_r) begin
            start_run = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_PICK_RD: begin
        if (d_r >= cnt_r) begin
          if (best_r == cnt_r) begin
            if (FCW'(k_r) + FCW'(1) >= FCW'(set_cls_r)) begin
              run_done_nxt = 1'b1;
              fp_det_nxt = '0;
              fp_cls_nxt = '0;
              state_nxt = ST_IDLE;
            end else begin
              k_nxt = k_r + CW'(1);
              have_last_nxt = 1'b0;
              d_nxt = '0;
              best_nxt = cnt_r;
              best_s_nxt = '0;
            end
          end else begin
            last_s_nxt = best_s_r;
            last_i_nxt = best_r;
            have_last_nxt = 1'b1;
            b_re = 1'b1;
            b_raddr = best_r[DW-1:0];
            state_nxt = ST_BOX_LATCH;
          end
        end else begin
          s_re = 1'b1;
          s_raddr = s_addr(d_r[DW-1:0], k_r);
          state_nxt = ST_PICK_CHK;
        end
      end

      ST_PICK_CHK: begin
        if (later && score_q > best_s_r) begin
          best_nxt = d_r;
          best_s_nxt = score_q;
        end
        d_nxt = d_r + CNTW'(1);
        state_nxt = ST_PICK_RD;
      end

      ST_BOX_LATCH: begin
        best_box_nxt = box_q;
        d_nxt = '0;
        state_nxt = ST_SUP_RD;
      end

      ST_SUP_RD: begin
        if (d_r >= cnt_r) begin
          d_nxt = '0;
          best_nxt = cnt_r;
          best_s_nxt = '0;
          state_nxt = ST_PICK_RD;
        end else begin
          s_re = 1'b1;
          s_raddr = s_addr(d_r[DW-1:0], k_r);
          b_re = 1'b1;
          b_raddr = d_r[DW-1:0];
          state_nxt = ST_SUP_CHK;
        end
      end

      ST_SUP_CHK: begin
        if (score_q != '0 && later) begin
          iou_start = 1'b1;
          state_nxt = ST_SUP_WAIT;
        end else begin
          d_nxt = d_r + CNTW'(1);
          state_nxt = ST_SUP_RD;
        end
      end

      ST_SUP_WAIT: begin
        if (iou_done) begin
          if (iou_hit) begin
            s_we = 1'b1;
            s_waddr = s_addr(d_r[DW-1:0], k_r);
            s_wdata = '0;
          end
          d_nxt = d_r + CNTW'(1);
          state_nxt = ST_SUP_RD;
        end
      end

      ST_F_START: begin
        res_nxt = '0;
        res_nxt.overflow = ovf_r;
        if (!run_done_r) begin
          state_nxt = ST_EMIT;
        end else if (fp_cls_r == '0 || CCW'(fp_cls_r) >= set_cls_r) begin
          cur_cls_nxt = '0;
          sv_d_nxt = fp_det_r;
          sv_c_nxt = '0;
          sv_ret_nxt = SV_FIRST;
          state_nxt = ST_SV_RD;
        end else begin
          cur_det_nxt = fp_det_r;
          cur_cls_nxt = fp_cls_r;
          state_nxt = ST_F_FIRST;
        end
      end

      ST_SV_RD: begin
        if (sv_d_r >= cnt_r) begin
          sv_go = 1'b1;
          found = cnt_r;
        end else begin
          s_re = 1'b1;
          s_raddr = s_addr(sv_d_r[DW-1:0], sv_c_r);
          state_nxt = ST_SV_CHK;
        end
      end

      ST_SV_CHK: begin
        if (score_q != '0) begin
          sv_go = 1'b1;
          found = sv_d_r;
        end else begin
          if (FCW'(sv_c_r) + FCW'(1) >= FCW'(set_cls_r)) begin
            sv_d_nxt = sv_d_r + CNTW'(1);
            sv_c_nxt = '0;
          end else begin
            sv_c_nxt = sv_c_r + CW'(1);
          end
          state_nxt = ST_SV_RD;
        end
      end

      ST_F_FIRST: begin
        if (cur_det_r >= cnt_r) begin
          fp_det_nxt = cnt_r;
          fp_cls_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          s_re = 1'b1;
          s_raddr = s_addr(cur_det_r[DW-1:0], cur_cls_r);
          b_re = 1'b1;
          b_raddr = cur_det_r[DW-1:0];
          state_nxt = ST_F_DATA;
        end
      end

      ST_F_DATA: begin
        res_nxt.valid_res   = 1'b1;
        res_nxt.out_left    = box_q.left;
        res_nxt.out_top     = box_q.top;
        res_nxt.out_width   = box_q.width;
        res_nxt.out_height  = box_q.height;
        res_nxt.class_index = 4'(cur_cls_r);
        res_nxt.out_score   = score_q;
        if (FCW'(cur_cls_r) + FCW'(1) >= FCW'(set_cls_r)) begin
          res_nxt.last_class = 1'b1;
          fp_det_nxt = cur_det_r + CNTW'(1);
          fp_cls_nxt = '0;
          sv_d_nxt = cur_det_r + CNTW'(1);
          sv_c_nxt = '0;
          sv_ret_nxt = SV_LAST;
          state_nxt = ST_SV_RD;
        end else begin
          fp_det_nxt = cur_det_r;
          fp_cls_nxt = cur_cls_r + CW'(1);
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (start_run) begin
      k_nxt = '0;
      have_last_nxt = 1'b0;
      d_nxt = '0;
      best_nxt = cnt_nxt;
      best_s_nxt = '0;
      state_nxt = ST_PICK_RD;
    end

    if (sv_go) begin
      if (sv_ret_r == SV_FIRST) begin
        cur_det_nxt = found;
        state_nxt = ST_F_FIRST;
      end else begin
        res_nxt.last_result = (found >= cnt_r);
        state_nxt = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) score_mem[s_waddr] <= s_wdata;
    if (s_re) score_q <= score_mem[s_raddr];
    if (b_we) box_mem[b_waddr] <= b_wdata;
    if (b_re) box_q <= box_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= IOU_THR_RESET;
      ncls_r      <= NUM_CLASSES_RESET;
      cnt_r       <= '0;
      cur_r       <= '0;
      set_cls_r   <= CCW'(1);
      ovf_r       <= 1'b0;
      run_done_r  <= 1'b0;
      fp_det_r    <= '0;
      fp_cls_r    <= '0;
      have_last_r <= 1'b0;
      eos_pend_r  <= 1'b0;
      sv_ret_r    <= SV_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      set_cls_r   <= set_cls_nxt;
      ovf_r       <= ovf_nxt;
      run_done_r  <= run_done_nxt;
      fp_det_r    <= fp_det_nxt;
      fp_cls_r    <= fp_cls_nxt;
      have_last_r <= have_last_nxt;
      eos_pend_r  <= eos_pend_nxt;
      sv_ret_r    <= sv_ret_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_IOU_THRESHOLD) thr_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_NUM_CLASSES) ncls_r <= cfg_data[4:0];
    end
  end

  always_ff @(posedge clk) begin
    fill_c_r   <= fill_c_nxt;
    fill_det_r <= fill_det_nxt;
    k_r        <= k_nxt;
    d_r        <= d_nxt;
    best_r     <= best_nxt;
    best_s_r   <= best_s_nxt;
    last_s_r   <= last_s_nxt;
    last_i_r   <= last_i_nxt;
    best_box_r <= best_box_nxt;
    sv_d_r     <= sv_d_nxt;
    sv_c_r     <= sv_c_nxt;
    cur_det_r  <= cur_det_nxt;
    cur_cls_r  <= cur_cls_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
